/* rtl/core/ged_pkg.sv */
// Shared types, constants and helpers for the Gilbert-Elliott packet dropper.
// No dependencies; every other file of the block uses it by scoped names.

package ged_pkg;

  // field and register widths
  localparam int TAG_W      = 16;
  localparam int PROB_W     = 17;
  localparam int DRAW_W     = 16;
  localparam int CNT_W      = 32;
  localparam int POS_W      = 7;
  localparam int PCT_W      = 7;
  localparam int MODE_W     = 2;
  localparam int RNG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // deterministic run length and generator defaults
  localparam logic [POS_W-1:0] CYCLE_LEN    = 7'd100;
  localparam logic [POS_W-1:0] CYCLE_LAST   = CYCLE_LEN - 7'd1;
  localparam logic [RNG_W-1:0] SEED_DEFAULT = 32'd51;
  localparam logic [RNG_W-1:0] SEED_ZERO_FIX = 32'd1;

  // reset values of the probability registers
  localparam logic [PROB_W-1:0] KEEP_GOOD_RESET    = 17'd65536;
  localparam logic [PROB_W-1:0] UNIFORM_DROP_RESET = 17'd1966;
  localparam logic [PCT_W-1:0]  DROP_PCT_RESET     = 7'd3;

  // bit positions in the mode register; deterministic wins over uniform
  localparam int MODE_BIT_UNIFORM = 0;
  localparam int MODE_BIT_DETERM  = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE              = 3'd0,
    REG_GOOD_TO_BAD       = 3'd1,
    REG_BAD_TO_GOOD       = 3'd2,
    REG_KEEP_IN_BAD       = 3'd3,
    REG_KEEP_IN_GOOD      = 3'd4,
    REG_UNIFORM_DROP_RATE = 3'd5,
    REG_DROP_PERCENT      = 3'd6,
    REG_RNG_SEED          = 3'd7
  } reg_idx_t;

  // configuration seen by the decision logic
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PROB_W-1:0] good_to_bad;
    logic [PROB_W-1:0] bad_to_good;
    logic [PROB_W-1:0] keep_in_bad;
    logic [PROB_W-1:0] keep_in_good;
    logic [PROB_W-1:0] uniform_drop_rate;
    logic [PCT_W-1:0]  drop_percent;
  } cfg_t;

  // per-packet channel state
  typedef struct packed {
    logic              channel_bad;
    logic [RNG_W-1:0]  rng_word;
    logic [POS_W-1:0]  cycle_pos;
    logic [CNT_W-1:0]  drop_cnt;
    logic [CNT_W-1:0]  recv_cnt;
  } state_t;

  // one xorshift32 step
  function automatic logic [RNG_W-1:0] xorshift_next(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] a;
    logic [RNG_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

/* rtl/core/ged_req_if.sv */
// Request channel of the packet dropper: valid/ready plus the packet tag.
// Depends on ged_pkg for the tag width.

interface ged_req_if;
  logic                      valid;
  logic                      ready;
  logic [ged_pkg::TAG_W-1:0] packet_tag;

  modport source (output valid, output packet_tag, input ready);
  modport sink   (input valid, input packet_tag, output ready);
endinterface

/* rtl/core/ged_res_if.sv */
// Result channel of the packet dropper: valid/ready plus the decision fields.
// Depends on ged_pkg for the field widths.

interface ged_res_if;
  logic                      valid;
  logic                      ready;
  logic [ged_pkg::TAG_W-1:0] tag_out;
  logic                      keep;
  logic [ged_pkg::CNT_W-1:0] dropped_total;
  logic [ged_pkg::CNT_W-1:0] received_total;

  modport source (output valid, output tag_out, output keep, output dropped_total,
                  output received_total, input ready);
  modport sink   (input valid, input tag_out, input keep, input dropped_total,
                  input received_total, output ready);
endinterface

/* rtl/core/ged_decide.sv */
// Keep/drop decision and next channel state for one packet.
// Depends on ged_pkg (cfg_t, state_t, xorshift_next).

module ged_decide (
  input  ged_pkg::cfg_t   cfg,
  input  ged_pkg::state_t cur,
  output ged_pkg::state_t nxt,
  output logic            keep
);

  logic [ged_pkg::RNG_W-1:0]  rng;
  logic [ged_pkg::PROB_W-1:0] keep_draw;
  logic [ged_pkg::PROB_W-1:0] trans_draw;
  logic [ged_pkg::POS_W-1:0]  pos_inc;

  // advance the generator, split into keep and transition draws
  always_comb begin
    rng        = ged_pkg::xorshift_next(cur.rng_word);
    keep_draw  = {1'b0, rng[ged_pkg::RNG_W-1 -: ged_pkg::DRAW_W]};
    trans_draw = {1'b0, rng[ged_pkg::DRAW_W-1:0]};
  end

  // position within the run of 100, wrapping
  assign pos_inc = (cur.cycle_pos == ged_pkg::CYCLE_LAST) ? '0 : cur.cycle_pos + 7'd1;

  // mode selection and state transition
  always_comb begin
    nxt          = cur;
    nxt.rng_word = rng;
    nxt.recv_cnt = cur.recv_cnt + 32'd1;
    if (cfg.mode[ged_pkg::MODE_BIT_DETERM]) begin
      nxt.cycle_pos = pos_inc;
      keep          = !({1'b0, pos_inc} < {1'b0, cfg.drop_percent});
    end else if (cfg.mode[ged_pkg::MODE_BIT_UNIFORM]) begin
      keep = keep_draw > cfg.uniform_drop_rate;
    end else if (!cur.channel_bad) begin
      keep = keep_draw < cfg.keep_in_good;
      if (trans_draw < cfg.good_to_bad) begin
        nxt.channel_bad = 1'b1;
      end
    end else begin
      keep = keep_draw < cfg.keep_in_bad;
      if (trans_draw < cfg.bad_to_good) begin
        nxt.channel_bad = 1'b0;
      end
    end
    nxt.drop_cnt = keep ? cur.drop_cnt : cur.drop_cnt + 32'd1;
  end

endmodule

/* rtl/core/gilbert_elliott_packet_dropper_top.sv */
// Top level of the Gilbert-Elliott packet dropper: config registers, input and
// result registers. Depends on ged_pkg, ged_req_if, ged_res_if and ged_decide.

// One result per request, in order. A request is taken every cycle when the
// result side keeps up. A request goes to the input register, its result to
// the result register. The rate is set by the per-packet state loop (xorshift
// step, draw compare, counter increments), combinational between the input
// and result registers. Configuration writes, including a seed load that
// restarts the random sequence (a seed of zero loads one), take effect on the
// next request and are meant to be made while no request is in flight.

module gilbert_elliott_packet_dropper_top (
  input  logic                           clk,
  input  logic                           rst,
  ged_req_if.sink                        req,
  ged_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [ged_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ged_pkg::CFG_DATA_W-1:0] cfg_data
);

  ged_pkg::cfg_t   cfg;
  ged_pkg::state_t st;
  ged_pkg::state_t st_next;
  logic            keep_next;

  logic                      s1_valid;
  logic [ged_pkg::TAG_W-1:0] s1_tag;
  logic                      s1_adv;

  logic                      out_valid;
  logic [ged_pkg::TAG_W-1:0] out_tag;
  logic                      out_keep;
  logic [ged_pkg::CNT_W-1:0] out_dropped;
  logic [ged_pkg::CNT_W-1:0] out_received;

  logic [ged_pkg::RNG_W-1:0] seed_load;
  logic                      seed_we;

  // handshake
  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= '0;
      cfg.good_to_bad       <= '0;
      cfg.bad_to_good       <= '0;
      cfg.keep_in_bad       <= '0;
      cfg.keep_in_good      <= ged_pkg::KEEP_GOOD_RESET;
      cfg.uniform_drop_rate <= ged_pkg::UNIFORM_DROP_RESET;
      cfg.drop_percent      <= ged_pkg::DROP_PCT_RESET;
    end else if (cfg_we) begin
      case (ged_pkg::reg_idx_t'(cfg_index))
        ged_pkg::REG_MODE:              cfg.mode <= cfg_data[ged_pkg::MODE_W-1:0];
        ged_pkg::REG_GOOD_TO_BAD:       cfg.good_to_bad <= cfg_data[ged_pkg::PROB_W-1:0];
        ged_pkg::REG_BAD_TO_GOOD:       cfg.bad_to_good <= cfg_data[ged_pkg::PROB_W-1:0];
        ged_pkg::REG_KEEP_IN_BAD:       cfg.keep_in_bad <= cfg_data[ged_pkg::PROB_W-1:0];
        ged_pkg::REG_KEEP_IN_GOOD:      cfg.keep_in_good <= cfg_data[ged_pkg::PROB_W-1:0];
        ged_pkg::REG_UNIFORM_DROP_RATE: begin
          cfg.uniform_drop_rate <= cfg_data[ged_pkg::PROB_W-1:0];
        end
        ged_pkg::REG_DROP_PERCENT:      cfg.drop_percent <= cfg_data[ged_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // seed write loads the generator; zero would lock it up
  assign seed_we   = cfg_we && (ged_pkg::reg_idx_t'(cfg_index) == ged_pkg::REG_RNG_SEED);
  assign seed_load = (cfg_data[ged_pkg::RNG_W-1:0] == '0) ? ged_pkg::SEED_ZERO_FIX
                                                          : cfg_data[ged_pkg::RNG_W-1:0];

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_tag <= req.packet_tag;
    end
  end

  ged_decide u_decide (
    .cfg  (cfg),
    .cur  (st),
    .nxt  (st_next),
    .keep (keep_next)
  );

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.channel_bad <= 1'b0;
      st.rng_word    <= ged_pkg::SEED_DEFAULT;
      st.cycle_pos   <= '0;
      st.drop_cnt    <= '0;
      st.recv_cnt    <= '0;
    end else begin
      if (s1_adv) begin
        st <= st_next;
      end
      if (seed_we) begin
        st.rng_word <= seed_load;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv) begin
      out_tag      <= s1_tag;
      out_keep     <= keep_next;
      out_dropped  <= st_next.drop_cnt;
      out_received <= st_next.recv_cnt;
    end
  end

  assign res.valid          = out_valid;
  assign res.tag_out        = out_tag;
  assign res.keep           = out_keep;
  assign res.dropped_total  = out_dropped;
  assign res.received_total = out_received;

  // each decision counts exactly one received packet
  a_recv_step: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> st.recv_cnt == $past(st.recv_cnt) + 32'd1)
    else $error("receive count did not step by one");

  // a drop decision bumps the drop counter
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !keep_next |=> st.drop_cnt == $past(st.drop_cnt) + 32'd1)
    else $error("drop count missed a dropped packet");

  // channel state only moves in Gilbert-Elliott mode
  a_chan_hold: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (cfg.mode != '0) |=> st.channel_bad == $past(st.channel_bad))
    else $error("channel state changed outside Gilbert-Elliott mode");

  // run position stays inside the run
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    st.cycle_pos < ged_pkg::CYCLE_LEN)
    else $error("run position out of range");

  // a held request is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_tag))
    else $error("stalled request lost");

endmodule
